/* hdl/utrq_pkg.sv */
package utrq_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CHAR_W     = 8;
    localparam int LVL_W      = 6;
    localparam int OUT_W      = 24;

    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    // input beat kind carried on tuser
    localparam logic MODE_CHAR  = 1'b0;
    localparam logic MODE_EMPTY = 1'b1;

    typedef enum logic [1:0] {
        STS_QUEUED  = 2'd0,
        STS_SENT    = 2'd1,
        STS_DROPPED = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    // command from controller to datapath
    typedef struct packed {
        logic              exec;
        logic              pop;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] wp,
                                                    input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] s;
        if (wp >= rp) begin
            s = {1'b0, wp} - {1'b0, rp};
        end else begin
            s = {1'b0, wp} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rp};
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [LVL_W-1:0] to_lvl(input logic [PTR_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[LVL_W-1:0];
    endfunction

endpackage

/* hdl/utrq_ctrl.sv */
module utrq_ctrl
    import utrq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [CHAR_W-1:0] i_char,
    input  t_dp_stat          i_stat,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CR   = 3'b010,
        S_ONE  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic              r_mode;
    logic [CHAR_W-1:0] r_char;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (!i_mode && i_char == CH_LF) ? S_CR : S_ONE;
                end
            end
            S_CR: begin
                // carriage return goes out ahead of the newline
                o_cmd.exec = i_stat.out_free;
                o_cmd.pop  = 1'b0;
                o_cmd.ch   = CH_CR;
                o_cmd.last = 1'b0;
                if (i_stat.out_free) begin
                    n_state = S_ONE;
                end
            end
            S_ONE: begin
                o_cmd.exec = i_stat.out_free;
                o_cmd.pop  = r_mode;
                o_cmd.ch   = r_char;
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_char <= i_char;
        end
    end

endmodule

/* hdl/utrq_dp.sv */
module utrq_dp
    import utrq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_out_data,
    output logic             o_out_last
);

    logic [CHAR_W-1:0] mem [RING_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    logic [PTR_W-1:0] r_rp, r_wp, r_peak;
    logic [PTR_W-1:0] n_rp, n_wp, n_peak, n_cnt, wp_next;
    logic             r_busy, n_busy;
    logic             wr_en;

    logic              r_out_valid;
    logic              r_send_valid, n_send_valid;
    logic [CHAR_W-1:0] r_send_byte, n_send_byte;
    t_status           r_status, n_status;
    logic [LVL_W-1:0]  r_fill, r_hwm;
    logic              r_last;

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign wp_next         = ptr_inc(r_wp);

    always_comb begin
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_busy       = r_busy;
        wr_en        = 1'b0;
        n_send_valid = 1'b0;
        n_send_byte  = '0;
        n_status     = STS_EMPTY;
        if (i_cmd.pop) begin
            if (r_wp != r_rp) begin
                n_rp         = ptr_inc(r_rp);
                n_send_valid = 1'b1;
                n_send_byte  = r_rd_data;
                n_status     = STS_SENT;
            end else begin
                n_busy   = 1'b0;
                n_status = STS_EMPTY;
            end
        end else if (r_busy) begin
            if (wp_next != r_rp) begin
                wr_en    = i_cmd.exec;
                n_wp     = wp_next;
                n_status = STS_QUEUED;
            end else begin
                n_status = STS_DROPPED;
            end
        end else begin
            // transmitter idle: hand the byte straight over
            n_busy       = 1'b1;
            n_send_valid = 1'b1;
            n_send_byte  = i_cmd.ch;
            n_status     = STS_SENT;
        end
        n_cnt  = ring_count(n_wp, n_rp);
        n_peak = (n_cnt > r_peak) ? n_cnt : r_peak;
    end

    // ring storage; read port follows the read pointer every cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wp] <= i_cmd.ch;
        end
        r_rd_data <= mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_peak      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_rp        <= n_rp;
                r_wp        <= n_wp;
                r_peak      <= n_peak;
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_send_valid <= n_send_valid;
            r_send_byte  <= n_send_byte;
            r_status     <= n_status;
            r_fill       <= to_lvl(n_cnt);
            r_hwm        <= to_lvl(n_peak);
            r_last       <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_last;
    assign o_out_data  = {1'b0, r_hwm, r_fill, r_status, r_send_byte, r_send_valid};

endmodule

/* hdl/uart_tx_ring_queue.sv */
// Transmit queue for a UART. Each input beat is a character (tuser = 0) or a
// transmitter-empty event (tuser = 1). A character goes straight out when the
// transmitter is idle, otherwise it is queued in a ring of RING_DEPTH bytes
// that keeps one slot free (RING_DEPTH - 1 usable); a character that finds the
// ring full is dropped with status 2 and must be resent. A newline is sent as
// carriage return then newline, two output beats, tlast on the second. An
// empty event pops the next byte or, with the ring empty, clears busy. Items
// are handled one at a time: the controller takes a beat only when idle and
// stalls while the output register waits on o_m_axis_tready; the ring's
// registered read port is loaded between items.
// No clearing pass after reset; the ring is ready at once.
module uart_tx_ring_queue
    import utrq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] char_in
    input  logic             i_s_axis_tuser,   // [0] mode
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // [0] send_valid, [8:1] send_byte,
                                               // [10:9] status, [16:11] fill_level,
                                               // [22:17] high_watermark, [23] zero
    output logic             o_m_axis_tlast    // last
);

    t_cmd     cmd;
    t_dp_stat stat;

    utrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .i_char     (i_s_axis_tdata),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    utrq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
